>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active
`define TCR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is active
`define TCR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/tcr_pkg.sv
`default_nettype none

package tcr_pkg;

	// Command channel payload: one received byte plus the live converter readings
	typedef struct packed {
		logic [7:0] rx_byte;
		logic [7:0] adc_x;
		logic [7:0] adc_y;
		logic [7:0] adc_z;
	} cmd_t;

	// Response channel payload: one transmitted byte
	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last_of_run;
		logic       led_on;
	} rsp_t;

	// Kind of response run
	typedef enum logic [2:0] {
		RK_META,
		RK_CHAN_SENS,
		RK_CHAN_ACT,
		RK_SAMPLE,
		RK_ACK
	} resp_kind_t;

	localparam int unsigned HDR_LEN  = 6;
	localparam int unsigned IDX_W    = 6;
	localparam int unsigned RUN_HEAD = 3;

	localparam logic [7:0] META_BODY [22] = '{
		8'd3, 8'd4, 8'd0, 8'd1, 8'd0, 8'd1,
		8'd4, 8'd10, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1,
		8'd13, 8'd2, 8'd0, 8'd4
	};

	localparam logic [7:0] CHAN_SENS_BODY [36] = '{
		8'd3, 8'd4, 8'd0, 8'd3, 8'd0, 8'd1,
		8'd11, 8'd1, 8'd0,
		8'd12, 8'd10, 8'd128, 8'd128, 8'd128, 8'd130, 8'd128, 8'd124,
		8'd128, 8'd128, 8'd128, 8'd128,
		8'd13, 8'd1, 8'd0, 8'd14, 8'd1, 8'd255, 8'd40, 8'd1, 8'd0,
		8'd41, 8'd1, 8'd1, 8'd42, 8'd1, 8'd8
	};

	localparam logic [7:0] CHAN_ACT_BODY [36] = '{
		8'd3, 8'd4, 8'd0, 8'd3, 8'd0, 8'd1,
		8'd11, 8'd1, 8'd1,
		8'd12, 8'd10, 8'd128, 8'd128, 8'd128, 8'd132, 8'd130, 8'd122,
		8'd126, 8'd128, 8'd128, 8'd128,
		8'd13, 8'd1, 8'd0, 8'd14, 8'd1, 8'd255, 8'd40, 8'd1, 8'd0,
		8'd41, 8'd1, 8'd1, 8'd42, 8'd1, 8'd8
	};

	// Total run length in bytes, including the three-byte run head
	function automatic logic [IDX_W-1:0] resp_len(input resp_kind_t kind);
		logic [IDX_W-1:0] len;
		case (kind)
			RK_META:      len = 6'd25;
			RK_CHAN_SENS: len = 6'd39;
			RK_CHAN_ACT:  len = 6'd39;
			RK_SAMPLE:    len = 6'd4;
			RK_ACK:       len = 6'd3;
			default:      len = 6'd3;
		endcase
		return len;
	endfunction

	// Byte at position idx of a run
	function automatic logic [7:0] resp_byte(input resp_kind_t kind,
			input logic [IDX_W-1:0] idx, input logic [7:0] sample);
		logic [IDX_W-1:0] bi;
		logic [7:0]       b;
		bi = idx - IDX_W'(RUN_HEAD);
		if (idx == 6'd0) begin
			b = 8'd1;
		end else if (idx == 6'd1) begin
			b = 8'd0;
		end else if (idx == 6'd2) begin
			b = 8'(resp_len(kind) - IDX_W'(RUN_HEAD));
		end else begin
			case (kind)
				RK_META:      b = META_BODY[bi[4:0]];
				RK_CHAN_SENS: b = CHAN_SENS_BODY[bi];
				RK_CHAN_ACT:  b = CHAN_ACT_BODY[bi];
				RK_SAMPLE:    b = sample;
				default:      b = 8'd0;
			endcase
		end
		return b;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/teds_command_responder.sv
`default_nettype none
// The first response byte of a frame passes the pending, run-generator and output registers.
// Throughput: one command byte per cycle unless cmd_stall is high; response bytes leave at one
// per cycle from the run generator while rsp_stall is low, a run of 3 to 39 bytes, with no gap between queued runs.
// Command input stalls while one decoded response waits behind the run in progress.
// Reset (arst_n low, asynchronous) clears the frame state, the LED flag and all queued runs.

module teds_command_responder #(
	parameter int unsigned MAX_DATA_LEN = 255
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            cmd_valid,
	output logic           cmd_stall,
	input  tcr_pkg::cmd_t  cmd,
	output logic           rsp_valid,
	input  wire            rsp_stall,
	output tcr_pkg::rsp_t  rsp
);
	import tcr_pkg::*;

	localparam logic [7:0] MAX_LEN = 8'(MAX_DATA_LEN);

	// frame collection state
	logic [7:0] hdr_q [HDR_LEN];
	logic [2:0] pos_q;
	logic [7:0] dcnt_q;
	logic [7:0] d0_q;
	logic [7:0] d1_q;
	logic       led_q;

	// decoded response waiting for the generator
	logic       pend_valid_q;
	resp_kind_t pend_kind_q;
	logic [7:0] pend_sample_q;
	logic       pend_led_q;

	// run in progress
	logic             act_valid_q;
	resp_kind_t       act_kind_q;
	logic [IDX_W-1:0] act_idx_q;
	logic [7:0]       act_sample_q;
	logic             act_led_q;

	// output register
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic       cmd_accept;
	logic       in_hdr;
	logic [7:0] b;
	logic [7:0] hn [HDR_LEN];
	logic [7:0] d0n;
	logic [7:0] d1n;
	logic [7:0] len;
	logic       done;
	logic       matched;
	resp_kind_t kind;
	logic [7:0] sample;
	logic       led_set;
	logic       new_pend;
	logic       out_free;
	logic       emit;
	logic       act_last;
	logic       act_free;
	logic       move;

	// Stall commands only while the held response cannot move into the generator
	assign cmd_accept = cmd_valid & ~cmd_stall;
	assign cmd_stall  = pend_valid_q & ~move;
	assign b          = cmd.rx_byte;
	assign in_hdr     = (pos_q < 3'(HDR_LEN));

	// Build the header as it stands after this byte
	always_comb begin
		for (int i = 0; i < HDR_LEN; i++) begin
			hn[i] = (in_hdr && pos_q == 3'(i)) ? b : hdr_q[i];
		end
	end

	// Capture the first two data bytes and detect frame end
	always_comb begin
		len = (hdr_q[5] > MAX_LEN) ? MAX_LEN : hdr_q[5];
		if (in_hdr) begin
			d0n  = (pos_q == 3'(HDR_LEN - 1)) ? 8'd0 : d0_q;
			d1n  = (pos_q == 3'(HDR_LEN - 1)) ? 8'd0 : d1_q;
			done = (pos_q == 3'(HDR_LEN - 1)) && (b == 8'd0);
		end else begin
			d0n  = (dcnt_q == 8'd0) ? b : d0_q;
			d1n  = (dcnt_q == 8'd1) ? b : d1_q;
			done = ({1'b0, dcnt_q} + 9'd1) >= {1'b0, len};
		end
	end

	// Match the completed frame against the command patterns, first match wins
	always_comb begin
		logic base;
		base    = (hn[0] == 8'd0) && (hn[4] == 8'd0);
		matched = 1'b1;
		kind    = RK_ACK;
		sample  = cmd.adc_z;
		led_set = 1'b0;
		if (hn[1] == 8'd1) begin
			sample = cmd.adc_x;
		end else if (hn[1] == 8'd2) begin
			sample = cmd.adc_y;
		end
		if (base && hn[1] == 8'd0 && hn[2] == 8'd1 && hn[3] == 8'd2 && hn[5] == 8'd2
				&& d0n == 8'd1 && d1n == 8'd0) begin
			kind = RK_META;
		end else if (base && hn[1] inside {[8'd1:8'd4]} && hn[2] == 8'd1 && hn[3] == 8'd2
				&& hn[5] == 8'd2 && d0n == 8'd3 && d1n == 8'd0) begin
			kind = (hn[1] == 8'd4) ? RK_CHAN_ACT : RK_CHAN_SENS;
		end else if (base && hn[1] inside {[8'd1:8'd3]} && hn[2] == 8'd3 && hn[3] == 8'd1
				&& hn[5] == 8'd1 && d0n == 8'd0) begin
			kind = RK_SAMPLE;
		end else if (base && hn[1] == 8'd4 && hn[2] == 8'd3 && hn[3] == 8'd2
				&& hn[5] == 8'd2) begin
			kind    = RK_ACK;
			led_set = (d1n == 8'd1);
		end else begin
			matched = 1'b0;
		end
	end

	assign new_pend = cmd_accept & done & matched;

	// Advance the frame collector on each command transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HDR_LEN; i++) hdr_q[i] <= 8'd0;
			pos_q  <= 3'd0;
			dcnt_q <= 8'd0;
			d0_q   <= 8'd0;
			d1_q   <= 8'd0;
			led_q  <= 1'b0;
		end else if (cmd_accept) begin
			for (int i = 0; i < HDR_LEN; i++) hdr_q[i] <= hn[i];
			if (done) begin
				pos_q  <= 3'd0;
				dcnt_q <= 8'd0;
				d0_q   <= 8'd0;
				d1_q   <= 8'd0;
				if (matched && led_set) led_q <= 1'b1;
			end else if (in_hdr) begin
				pos_q  <= pos_q + 3'd1;
				dcnt_q <= 8'd0;
				d0_q   <= d0n;
				d1_q   <= d1n;
			end else begin
				dcnt_q <= dcnt_q + 8'd1;
				d0_q   <= d0n;
				d1_q   <= d1n;
			end
		end
	end

	// Run generator handshakes
	assign out_free = ~rsp_valid_q | ~rsp_stall;
	assign emit     = act_valid_q & out_free;
	assign act_last = (act_idx_q == resp_len(act_kind_q) - 6'd1);
	assign act_free = ~act_valid_q | (emit & act_last);
	assign move     = pend_valid_q & act_free;

	// Hold one decoded response until the generator takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (new_pend) begin
			pend_valid_q <= 1'b1;
		end else if (move) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (new_pend) begin
			pend_kind_q   <= kind;
			pend_sample_q <= sample;
			pend_led_q    <= led_q | led_set;
		end
	end

	// Step through the active run, loading the next one when it ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_valid_q <= 1'b0;
		end else if (move) begin
			act_valid_q <= 1'b1;
		end else if (act_free) begin
			act_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			act_kind_q   <= pend_kind_q;
			act_idx_q    <= '0;
			act_sample_q <= pend_sample_q;
			act_led_q    <= pend_led_q;
		end else if (emit) begin
			act_idx_q <= act_idx_q + 6'd1;
		end
	end

	// Output register: load a byte whenever the previous one is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= act_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q.tx_byte     <= resp_byte(act_kind_q, act_idx_q, act_sample_q);
			rsp_q.last_of_run <= act_last;
			rsp_q.led_on      <= act_led_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

>>> rtl/core/tcr_checker.sv
`default_nettype none
`include "assert_macros.svh"

module tcr_checker (
	input wire           clk,
	input wire           arst_n,
	input wire           rsp_valid,
	input wire           rsp_stall,
	input tcr_pkg::rsp_t rsp
);
	import tcr_pkg::*;

	// A stalled response byte stays put
	`TCR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp changed while stalled")

	// Bytes of one run follow without gaps
	`TCR_ASSERT_NEXT(a_run_gapless, rsp_valid && !rsp_stall && !rsp.last_of_run, rsp_valid, "gap inside a response run")

	// LED state is the same on every byte of a run
	`TCR_ASSERT_NEXT(a_run_led, rsp_valid && !rsp_stall && !rsp.last_of_run, rsp.led_on == $past(rsp.led_on), "led_on changed inside a run")

endmodule

bind teds_command_responder tcr_checker u_tcr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire

>>> sim/tcr_tb_pkg.sv
`timescale 1ns / 1ps

package tcr_tb_pkg;

	// Channel addressed by header byte 1
	localparam logic [7:0] CH_TIM      = 8'd0;
	localparam logic [7:0] CH_X        = 8'd1;
	localparam logic [7:0] CH_Y        = 8'd2;
	localparam logic [7:0] CH_Z        = 8'd3;
	localparam logic [7:0] CH_ACTUATOR = 8'd4;

	// Command class (header byte 2) and function (header byte 3)
	localparam logic [7:0] CLS_TEDS       = 8'd1;
	localparam logic [7:0] CLS_OPERATE    = 8'd3;
	localparam logic [7:0] FN_READ_TEDS   = 8'd2;
	localparam logic [7:0] FN_READ_SAMPLE = 8'd1;
	localparam logic [7:0] FN_WRITE_ACT   = 8'd2;

	// First data byte of a TEDS query, second data byte of an actuator write
	localparam logic [7:0] TEDS_META = 8'd1;
	localparam logic [7:0] TEDS_CHAN = 8'd3;
	localparam logic [7:0] LED_SET   = 8'd1;

endpackage

>>> sim/teds_response_checker.sv
`timescale 1ns / 1ps

module teds_response_checker #(
	parameter int unsigned MAX_DATA_LEN = 255
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           cmd_valid,
	input  wire           cmd_stall,
	input  tcr_pkg::cmd_t cmd,
	input  wire           rsp_valid,
	input  wire           rsp_stall,
	input  tcr_pkg::rsp_t rsp,
	output int            fail_count,
	output int            pending,
	output int            cmd_count,
	output int            byte_count,
	output int            meta_runs,
	output int            teds_runs,
	output int            sample_runs,
	output int            ack_runs
);
	import tcr_pkg::*;
	import tcr_tb_pkg::*;

	localparam int HDR_BYTES   = 6;
	localparam int MAX_REPORTS = 40;

	localparam logic [7:0] META_TEDS [22] = '{
		8'd3, 8'd4, 8'd0, 8'd1, 8'd0, 8'd1,
		8'd4, 8'd10, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1,
		8'd13, 8'd2, 8'd0, 8'd4
	};

	localparam logic [7:0] SENSOR_TEDS [36] = '{
		8'd3, 8'd4, 8'd0, 8'd3, 8'd0, 8'd1,
		8'd11, 8'd1, 8'd0,
		8'd12, 8'd10, 8'd128, 8'd128, 8'd128, 8'd130, 8'd128, 8'd124,
		8'd128, 8'd128, 8'd128, 8'd128,
		8'd13, 8'd1, 8'd0, 8'd14, 8'd1, 8'd255, 8'd40, 8'd1, 8'd0,
		8'd41, 8'd1, 8'd1, 8'd42, 8'd1, 8'd8
	};

	localparam logic [7:0] ACTUATOR_TEDS [36] = '{
		8'd3, 8'd4, 8'd0, 8'd3, 8'd0, 8'd1,
		8'd11, 8'd1, 8'd1,
		8'd12, 8'd10, 8'd128, 8'd128, 8'd128, 8'd132, 8'd130, 8'd122,
		8'd126, 8'd128, 8'd128, 8'd128,
		8'd13, 8'd1, 8'd0, 8'd14, 8'd1, 8'd255, 8'd40, 8'd1, 8'd0,
		8'd41, 8'd1, 8'd1, 8'd42, 8'd1, 8'd8
	};

	// Frame assembly state of the predicted responder
	logic [7:0] hdr [HDR_BYTES];
	logic [2:0] hdr_pos;
	logic [7:0] data_seen;
	logic [7:0] data_kept [2];
	logic       led_lit;
	rsp_t       resp_due [$];

	function automatic bit header_is(input logic [7:0] h1, h2, h3, h5);
		return hdr[0] == 8'd0 && hdr[1] == h1 && hdr[2] == h2 && hdr[3] == h3 &&
			hdr[4] == 8'd0 && hdr[5] == h5;
	endfunction

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS) $display("ERROR at %0t ns: %s", $time, msg);
	endtask

	// Advance the frame by one received byte and queue the response it completes
	function automatic void predict_transfer(input cmd_t c);
		logic [7:0] d0;
		logic [7:0] d1;
		logic [7:0] sample;
		logic [7:0] run [$];
		int         len;
		int         k;
		int         i;
		bit         done;
		bit         hit;
		resp_kind_t kind;
		rsp_t       r;
		done   = 1'b0;
		hit    = 1'b0;
		kind   = RK_ACK;
		sample = 8'd0;
		if (hdr_pos < HDR_BYTES) begin
			hdr[hdr_pos] = c.rx_byte;
			hdr_pos = hdr_pos + 3'd1;
			if (hdr_pos == HDR_BYTES) begin
				data_seen = 8'd0;
				data_kept[0] = 8'd0;
				data_kept[1] = 8'd0;
				if (hdr[5] == 8'd0) done = 1'b1;
			end
		end else begin
			if (data_seen < 2) data_kept[data_seen] = c.rx_byte;
			data_seen = data_seen + 8'd1;
			len = (hdr[5] > MAX_DATA_LEN) ? MAX_DATA_LEN : hdr[5];
			if (data_seen >= len) done = 1'b1;
		end
		if (!done) return;

		// Latch the kept data and restart the header for the next frame
		d0 = data_kept[0];
		d1 = data_kept[1];
		hdr_pos = 3'd0;
		data_seen = 8'd0;
		data_kept[0] = 8'd0;
		data_kept[1] = 8'd0;

		// Try the command patterns in priority order
		if (header_is(CH_TIM, CLS_TEDS, FN_READ_TEDS, 8'd2) && d0 == TEDS_META && d1 == 8'd0) begin
			hit = 1'b1;
			kind = RK_META;
		end
		for (k = CH_X; k <= CH_ACTUATOR && !hit; k++) begin
			if (header_is(8'(k), CLS_TEDS, FN_READ_TEDS, 8'd2) && d0 == TEDS_CHAN && d1 == 8'd0) begin
				hit = 1'b1;
				kind = (k == CH_ACTUATOR) ? RK_CHAN_ACT : RK_CHAN_SENS;
			end
		end
		for (k = CH_X; k <= CH_Z && !hit; k++) begin
			if (header_is(8'(k), CLS_OPERATE, FN_READ_SAMPLE, 8'd1) && d0 == 8'd0) begin
				hit = 1'b1;
				kind = RK_SAMPLE;
				sample = (k == CH_X) ? c.adc_x : (k == CH_Y) ? c.adc_y : c.adc_z;
			end
		end
		if (!hit && header_is(CH_ACTUATOR, CLS_OPERATE, FN_WRITE_ACT, 8'd2)) begin
			hit = 1'b1;
			kind = RK_ACK;
			if (d1 == LED_SET) led_lit = 1'b1;
		end
		if (!hit) return;

		// Build the run: two fixed bytes, the body length, then the body
		run.push_back(8'd1);
		run.push_back(8'd0);
		case (kind)
			RK_META: begin
				run.push_back(8'd22);
				for (i = 0; i < 22; i++) run.push_back(META_TEDS[i]);
				meta_runs++;
			end
			RK_CHAN_SENS: begin
				run.push_back(8'd36);
				for (i = 0; i < 36; i++) run.push_back(SENSOR_TEDS[i]);
				teds_runs++;
			end
			RK_CHAN_ACT: begin
				run.push_back(8'd36);
				for (i = 0; i < 36; i++) run.push_back(ACTUATOR_TEDS[i]);
				teds_runs++;
			end
			RK_SAMPLE: begin
				run.push_back(8'd1);
				run.push_back(sample);
				sample_runs++;
			end
			default: begin
				run.push_back(8'd0);
				ack_runs++;
			end
		endcase
		for (i = 0; i < run.size(); i++) begin
			r.tx_byte = run[i];
			r.last_of_run = (i == run.size() - 1);
			r.led_on = led_lit;
			resp_due.push_back(r);
		end
	endfunction

	// Watch both channels: predict on each command transfer, compare each response transfer
	always @(posedge clk or negedge arst_n) begin
		rsp_t due;
		if (!arst_n) begin
			for (int i = 0; i < HDR_BYTES; i++) hdr[i] = 8'd0;
			hdr_pos = 3'd0;
			data_seen = 8'd0;
			data_kept[0] = 8'd0;
			data_kept[1] = 8'd0;
			led_lit = 1'b0;
			resp_due.delete();
			cmd_count = 0;
			byte_count = 0;
			meta_runs = 0;
			teds_runs = 0;
			sample_runs = 0;
			ack_runs = 0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				cmd_count++;
				predict_transfer(cmd);
			end
			if (rsp_valid && !rsp_stall) begin
				if (resp_due.size() == 0) begin
					report_mismatch($sformatf("response byte %0d (0x%02h) with nothing expected",
						byte_count, rsp.tx_byte));
				end else begin
					due = resp_due.pop_front();
					if (rsp.tx_byte !== due.tx_byte)
						report_mismatch($sformatf("byte %0d: tx_byte 0x%02h, expected 0x%02h",
							byte_count, rsp.tx_byte, due.tx_byte));
					if (rsp.last_of_run !== due.last_of_run)
						report_mismatch($sformatf("byte %0d: last_of_run %b, expected %b",
							byte_count, rsp.last_of_run, due.last_of_run));
					if (rsp.led_on !== due.led_on)
						report_mismatch($sformatf("byte %0d: led_on %b, expected %b",
							byte_count, rsp.led_on, due.led_on));
				end
				byte_count++;
			end
		end
		pending = resp_due.size();
	end

endmodule

>>> sim/teds_command_responder_tb.sv
`timescale 1ns / 1ps

module teds_command_responder_tb;
	import tcr_pkg::*;
	import tcr_tb_pkg::*;

	localparam int HOLD_OFF_CYCLES = 300;
	localparam int IDLE_LIMIT      = 4000;
	localparam int DRAIN_CYCLES    = 20;
	localparam int RANDOM_BYTES    = 20;

	typedef enum int {RX_FREE, RX_SPARSE, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	int fail_count;
	int pending;
	int cmd_count;
	int byte_count;
	int meta_runs;
	int teds_runs;
	int sample_runs;
	int ack_runs;

	int burst_left    = 0;
	int sent_bytes    = 0;
	int hold_requests = 0;
	int idle_cycles   = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	teds_command_responder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	teds_response_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending),
		.cmd_count  (cmd_count),
		.byte_count (byte_count),
		.meta_runs  (meta_runs),
		.teds_runs  (teds_runs),
		.sample_runs(sample_runs),
		.ack_runs   (ack_runs)
	);

	// Converter reading, biased toward the rails
	function automatic logic [7:0] rand_adc();
		case ($urandom_range(0, 5))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Offer one byte in bursts with random gaps; hold it until the transfer
	task automatic send_byte(input logic [7:0] b);
		cmd_t item;
		int   gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 10);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			if (gap != 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		item.rx_byte = b;
		item.adc_x = rand_adc();
		item.adc_y = rand_adc();
		item.adc_z = rand_adc();
		cmd <= item;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		burst_left--;
		sent_bytes++;
	endtask

	// Send a six-byte header followed by h5 data bytes; bytes past the second are random
	task automatic send_frame(input logic [7:0] h0, h1, h2, h3, h4, h5,
			input logic [7:0] d0, d1);
		int i;
		send_byte(h0);
		send_byte(h1);
		send_byte(h2);
		send_byte(h3);
		send_byte(h4);
		send_byte(h5);
		for (i = 0; i < h5; i++) begin
			if (i == 0) send_byte(d0);
			else if (i == 1) send_byte(d1);
			else send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// Drop valid and wait until every predicted response byte has arrived
	task automatic drain_responses();
		cmd_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Receiver: stall on shifting patterns, plus one long hold-off on request
	initial begin : rsp_side
		rx_mode_t mode;
		int       mode_left;
		int       holds_served;
		mode = RX_FREE;
		mode_left = 0;
		holds_served = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_served != hold_requests) begin
				holds_served++;
				rsp_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(8, 60);
			end
			mode_left--;
			case (mode)
				RX_FREE:     rsp_stall <= 1'b0;
				RX_SPARSE:   rsp_stall <= ($urandom_range(0, 2) == 0);
				RX_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
				default:     rsp_stall <= (mode_left % 4 == 0);
			endcase
		end
	end

	// Watchdog: end the run when no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog: no transfer for %0d cycles, %0d bytes outstanding",
					IDLE_LIMIT, pending);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [7:0] hb [6];
		logic [7:0] d0;
		logic [7:0] d1;
		int         pick;
		int         k;
		int         i;
		int         start_bytes;
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty data: the frame ends on the header and matches nothing
		send_frame(8'd0, CH_TIM, CLS_TEDS, FN_READ_TEDS, 8'd0, 8'd0, 8'd0, 8'd0);
		// Actuator write that leaves the LED off
		send_frame(8'd0, CH_ACTUATOR, CLS_OPERATE, FN_WRITE_ACT, 8'd0, 8'd2, 8'hFF, 8'd0);
		send_frame(8'd0, CH_TIM, CLS_TEDS, FN_READ_TEDS, 8'd0, 8'd2, TEDS_META, 8'd0);
		// Short data: one data byte, the second reads as zero
		for (k = CH_X; k <= CH_Z; k++)
			send_frame(8'd0, 8'(k), CLS_OPERATE, FN_READ_SAMPLE, 8'd0, 8'd1, 8'd0, 8'd0);
		// Near misses that must be dropped silently
		send_frame(8'd0, CH_X, CLS_OPERATE, FN_READ_SAMPLE, 8'd0, 8'd1, 8'hFF, 8'd0);
		send_frame(8'd0, CH_TIM, CLS_TEDS, FN_READ_TEDS, 8'd0, 8'd2, TEDS_META, 8'd1);
		// Long data: only the first two data bytes count, the rest are skipped
		send_frame(8'd0, CH_TIM, CLS_TEDS, FN_READ_TEDS, 8'd0, 8'd12, TEDS_META, 8'd0);
		// Light the LED, then check that it sticks on later runs
		send_frame(8'd0, CH_ACTUATOR, CLS_OPERATE, FN_WRITE_ACT, 8'd0, 8'd2, 8'd0, LED_SET);
		send_frame(8'd0, CH_ACTUATOR, CLS_OPERATE, FN_WRITE_ACT, 8'd0, 8'd2, 8'd0, 8'd0);
		send_frame(8'd0, CH_Z, CLS_OPERATE, FN_READ_SAMPLE, 8'd0, 8'd1, 8'd0, 8'd0);
		drain_responses();

		// Hold the receiver off while channel TEDS queries for channels X, Y, Z and the actuator keep coming
		hold_requests++;
		for (i = 0; i < 4; i++)
			send_frame(8'd0, 8'(CH_X + i), CLS_TEDS, FN_READ_TEDS,
				8'd0, 8'd2, TEDS_CHAN, 8'd0);
		drain_responses();

		// Random frames: mostly valid commands, some near misses, some noise
		start_bytes = sent_bytes;
		while (sent_bytes - start_bytes < RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			hb = '{8'd0, CH_TIM, CLS_TEDS, FN_READ_TEDS, 8'd0, 8'd2};
			d0 = TEDS_META;
			d1 = 8'd0;
			case ($urandom_range(0, 3))
				1: begin
					hb[1] = 8'($urandom_range(CH_X, CH_ACTUATOR));
					d0 = TEDS_CHAN;
				end
				2: begin
					hb[1] = 8'($urandom_range(CH_X, CH_Z));
					hb[2] = CLS_OPERATE;
					hb[3] = FN_READ_SAMPLE;
					hb[5] = 8'd1;
					d0 = 8'd0;
				end
				3: begin
					hb[1] = CH_ACTUATOR;
					hb[2] = CLS_OPERATE;
					hb[3] = FN_WRITE_ACT;
					d0 = 8'($urandom_range(0, 255));
					d1 = ($urandom_range(0, 1) == 0) ? LED_SET : 8'($urandom_range(0, 255));
				end
				default: ;
			endcase
			if (pick >= 90) begin
				for (i = 0; i < 5; i++) hb[i] = 8'($urandom_range(0, 255));
				hb[5] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(5, 40))
					: 8'($urandom_range(0, 4));
				d0 = 8'($urandom_range(0, 255));
				d1 = 8'($urandom_range(0, 255));
			end else if (pick >= 70) begin
				i = $urandom_range(0, 7);
				if (i < 5) hb[i] = 8'($urandom_range(0, 255));
				else if (i == 5) hb[5] = 8'($urandom_range(0, 4));
				else if (i == 6) d0 = 8'($urandom_range(0, 255));
				else d1 = 8'($urandom_range(0, 255));
			end
			send_frame(hb[0], hb[1], hb[2], hb[3], hb[4], hb[5], d0, d1);
		end

		// Let the last runs drain and catch any stray bytes
		drain_responses();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Summary: %0d command bytes in, %0d response bytes checked",
			cmd_count, byte_count);
		$display("Summary: runs of %0d meta TEDS, %0d channel TEDS, %0d samples, %0d acks",
			meta_runs, teds_runs, sample_runs, ack_runs);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
